@@ src/rip_load_then_call_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the load-then-call scanner
// Concurrent checks on the rising edge of clock, disabled while reset is high.
// They become empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RIP_LOAD_THEN_CALL_SCANNER_MACROS_SVH
`define RIP_LOAD_THEN_CALL_SCANNER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RLTCS_CHECK(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rltcs check failed");

// The consequent must hold in the cycle after the antecedent.
`define RLTCS_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rltcs check failed");

`else

`define RLTCS_CHECK(label, ante, cons)
`define RLTCS_CHECK_NEXT(label, ante, cons)

`endif

`endif

@@ src/rltcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rltcs_pkg
// Shared widths, opcode bytes, register indexes and control structs of the
// load-then-call scanner.
// ----------------------------------------------------------------------------
package rltcs_pkg;

   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 64;
   localparam int CNT_W     = 32;
   localparam int SIZE_W    = 32;
   localparam int DISP_W    = 32;
   localparam int HIST_DEPTH = 5;

   // Opcode bytes of the two instructions.
   localparam logic [BYTE_W-1:0] OP_CALL   = 8'hE8;
   localparam logic [BYTE_W-1:0] OP_REX_W  = 8'h48;
   localparam logic [BYTE_W-1:0] OP_MOV    = 8'h8B;
   localparam logic [BYTE_W-1:0] OP_RIPREL = 8'h05;

   // A call is recognized when its last displacement byte arrives, four bytes
   // after the opcode; its destination is relative to the end of the call.
   localparam int CALL_LEN = 5;
   localparam int CALL_LAG = 4;
   localparam logic [ADDR_W-1:0] CALL_BIAS = ADDR_W'(CALL_LEN - CALL_LAG);

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE   = 2'd2;

   // The hit vector of the cell row is counted in groups of eight bits.
   // Windows of up to 64 bytes give at most 8 groups, so 7 bits hold the sum.
   localparam int GRP_SIZE  = 8;
   localparam int GRP_CNT_W = 4;
   localparam int POP_W     = 7;

   // Per-byte control handed from the front end to the cell row.
   typedef struct packed {
      logic step;      // an item was accepted this cycle
      logic last;      // it closes the section
      logic load_hit;  // a counted load begins two bytes back
      logic call_hit;  // a call to the target ends with this byte
      logic enable;    // all three registers are nonzero
   } step_ctl_type;

   // Status travelling with the hit counts down the count pipeline.
   typedef struct packed {
      logic valid;
      logic last;
      logic enable;
   } flow_type;

endpackage

@@ src/rltcs_cell.sv @@
// ----------------------------------------------------------------------------
// rltcs_cell
// One age slot of the pending-load row: holds one waiting load and passes it
// to the next older slot on every accepted byte.
// ----------------------------------------------------------------------------
module rltcs_cell (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic flush,
   input  logic shift_in,
   input  logic hit_here,
   output logic bit_out,
   output logic scored
);

   logic bit_ff;
   logic bit_in;

   // A load arriving in this slot meets a matching call and is retired.
   assign scored = step & shift_in & hit_here;

   always_comb begin
      bit_in = bit_ff;
      if (step) begin
         bit_in = flush ? 1'b0 : (shift_in & ~hit_here);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_out = bit_ff;

endmodule

@@ src/rltcs_chain.sv @@
// ----------------------------------------------------------------------------
// rltcs_chain
// Row of pending-load cells plus the first stage of the hit count: the
// retired loads of one byte are counted per group of eight and registered.
// ----------------------------------------------------------------------------
`include "rip_load_then_call_scanner_macros.svh"

module rltcs_chain #(
   parameter  int WINDOW_BYTES = 32,
   localparam int NCELL = WINDOW_BYTES - 3,
   localparam int GRP_N = (NCELL + rltcs_pkg::GRP_SIZE - 1) / rltcs_pkg::GRP_SIZE
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rltcs_pkg::step_ctl_type ctl,
   input  logic                    adv,
   output rltcs_pkg::flow_type     s1_flow,
   output logic [GRP_N-1:0][rltcs_pkg::GRP_CNT_W-1:0] s1_grp
);
   import rltcs_pkg::*;

   localparam int PAD_N = GRP_N * GRP_SIZE;

   logic [NCELL-1:0] bits;
   logic [NCELL-1:0] scored;
   logic [PAD_N-1:0] scored_pad;
   logic [GRP_N-1:0][GRP_CNT_W-1:0] grp_cnt;

   flow_type s1_flow_ff;
   flow_type s1_flow_in;
   logic [GRP_N-1:0][GRP_CNT_W-1:0] s1_grp_ff;
   logic [GRP_N-1:0][GRP_CNT_W-1:0] s1_grp_in;

   // Slot j holds a load of age j bytes. Slots 0 and 1 are too young to see a
   // call; the oldest slot is the last one whose window is still open.
   for (genvar j = 0; j < NCELL; j++) begin : g_cell
      logic shift_in;
      logic hit_here;
      if (j == 0) begin : g_head
         assign shift_in = ctl.load_hit;
      end else begin : g_link
         assign shift_in = bits[j-1];
      end
      if (j >= 2) begin : g_win
         assign hit_here = ctl.call_hit;
      end else begin : g_young
         assign hit_here = 1'b0;
      end
      rltcs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (ctl.step),
         .flush    (ctl.last),
         .shift_in (shift_in),
         .hit_here (hit_here),
         .bit_out  (bits[j]),
         .scored   (scored[j])
      );
   end

   assign scored_pad = PAD_N'(scored);

   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         grp_cnt[g] = '0;
         for (int b = 0; b < GRP_SIZE; b++) begin
            grp_cnt[g] = grp_cnt[g] + GRP_CNT_W'(scored_pad[g*GRP_SIZE + b]);
         end
      end
   end

   always_comb begin
      s1_flow_in = s1_flow_ff;
      s1_grp_in  = s1_grp_ff;
      if (adv) begin
         s1_flow_in.valid  = ctl.step;
         s1_flow_in.last   = ctl.step & ctl.last;
         s1_flow_in.enable = ctl.enable;
         s1_grp_in         = grp_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_flow_ff <= '0;
      end else begin
         s1_flow_ff <= s1_flow_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_grp_ff <= s1_grp_in;
   end

   assign s1_flow = s1_flow_ff;
   assign s1_grp  = s1_grp_ff;

   // Loads retire only on an accepted byte that completes a matching call.
   `RLTCS_CHECK(a_score_needs_call, !ctl.step || !ctl.call_hit, scored == '0)
   // The row is empty after the last byte of a section.
   `RLTCS_CHECK_NEXT(a_row_flushed, ctl.step && ctl.last, bits == '0)

endmodule

@@ src/rltcs_tally.sv @@
// ----------------------------------------------------------------------------
// rltcs_tally
// Sums the group counts, accumulates the saturating hit counter and holds the
// result register of the output channel.
// ----------------------------------------------------------------------------
`include "rip_load_then_call_scanner_macros.svh"

module rltcs_tally #(
   parameter int GRP_N = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  rltcs_pkg::flow_type                      s1_flow,
   input  logic [GRP_N-1:0][rltcs_pkg::GRP_CNT_W-1:0] s1_grp,
   output logic                                     adv,
   input  logic                                     rsp_tready,
   output logic                                     rsp_tvalid,
   output logic [rltcs_pkg::CNT_W-1:0]              rsp_tdata
);
   import rltcs_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   flow_type           s2_flow_ff;
   flow_type           s2_flow_in;
   logic [POP_W-1:0]   s2_pop_ff;
   logic [POP_W-1:0]   s2_pop_in;
   logic [CNT_W-1:0]   hit_ff;
   logic [CNT_W-1:0]   hit_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [CNT_W-1:0]   rsp_data_ff;
   logic [CNT_W-1:0]   rsp_data_in;

   logic [POP_W-1:0]   pop_sum;
   logic [SUM_W-1:0]   sum_ext;
   logic [CNT_W-1:0]   hit_sat;

   always_comb begin
      pop_sum = '0;
      for (int g = 0; g < GRP_N; g++) begin
         pop_sum = pop_sum + POP_W'(s1_grp[g]);
      end
   end

   assign sum_ext = {1'b0, hit_ff} + SUM_W'(s2_pop_ff);
   assign hit_sat = sum_ext[CNT_W] ? CNT_MAX : sum_ext[CNT_W-1:0];

   // The pipeline holds only when a section result is due and the result
   // register is still occupied.
   assign adv = !(s2_flow_ff.valid && s2_flow_ff.last && rsp_valid_ff && !rsp_tready);

   always_comb begin
      s2_flow_in   = s2_flow_ff;
      s2_pop_in    = s2_pop_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (adv) begin
         s2_flow_in = s1_flow;
         s2_pop_in  = pop_sum;
         if (s2_flow_ff.valid) begin
            if (s2_flow_ff.last) begin
               hit_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = s2_flow_ff.enable ? hit_sat : '0;
            end else if (s2_flow_ff.enable) begin
               hit_in = hit_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_flow_ff   <= '0;
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_flow_ff   <= s2_flow_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_pop_ff   <= s2_pop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A hold is only ever caused by a waiting result.
   `RLTCS_CHECK(a_hold_has_cause, !adv, rsp_valid_ff)
   // A section closing in this stage always produces a result.
   `RLTCS_CHECK_NEXT(a_last_gives_result, adv && s2_flow_ff.valid && s2_flow_ff.last,
                     rsp_valid_ff)
   // A disabled scan reports zero, and the counter restarts after every section.
   `RLTCS_CHECK_NEXT(a_disabled_zero,
                     adv && s2_flow_ff.valid && s2_flow_ff.last && !s2_flow_ff.enable,
                     rsp_data_ff == '0 && hit_ff == '0)

endmodule

@@ src/rip_load_then_call_scanner.sv @@
// ----------------------------------------------------------------------------
// rip_load_then_call_scanner
// Counts RIP-relative 64-bit loads that are followed, within a short window,
// by a near call to a given target address.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes the bytes of one code section in address order, one
//   item per byte, with req_tlast on the final byte. On that byte the rsp
//   channel later delivers one item: the number of loads (48 8B 05) whose
//   window held an E8 call landing on the target address, saturating at
//   2^32-1. A zero target, base or size gives a count of zero.
//   The user must use the csr port, which writes target, base and section
//   size, only while the block is idle; the block itself does not enforce it.
//   Throughput is one byte per clock cycle, back to back while req_tready is
//   high. The hit counts pass the cell row stage and the group-sum stage in
//   front of the saturating accumulator, which loads the result into an output
//   register, so bytes of the next section keep flowing while it waits. Only
//   when a second section end reaches the accumulator with that register
//   still full does req_tready drop until rsp_tready takes the waiting item.
//   Reset clears the configuration, byte history, byte index and valid flags
//   and empties the pipeline; no clearing pass follows it.
// ----------------------------------------------------------------------------
`include "rip_load_then_call_scanner_macros.svh"

module rip_load_then_call_scanner #(
   parameter int WINDOW_BYTES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // Byte stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rltcs_pkg::BYTE_W-1:0]      req_tdata,   // [7:0] code_byte
   input  logic                              req_tlast,   // last
   // Section result.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rltcs_pkg::CNT_W-1:0]       rsp_tdata,   // [31:0] match_count
   // Configuration writes: 0 target address, 1 base address, 2 section length.
   input  logic                              csr_wr_en,
   input  logic [rltcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rltcs_pkg::ADDR_W-1:0]      csr_wdata
);
   import rltcs_pkg::*;

   localparam int NCELL = WINDOW_BYTES - 3;
   localparam int GRP_N = (NCELL + GRP_SIZE - 1) / GRP_SIZE;

   // Configuration registers.
   logic [ADDR_W-1:0] target_ff, target_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [SIZE_W-1:0] size_ff, size_in;

   // bias_ff is target - base - 1. A call whose displacement ends with byte n
   // reaches the target exactly when the sign-extended displacement equals
   // bias - n, which k_ff tracks as n advances. This turns the destination
   // add into a plain equality on every byte.
   logic [ADDR_W-1:0] bias_ff, bias_in, bias_cfg;
   logic [ADDR_W-1:0] k_ff, k_in;

   // Stream state: the last five bytes and the saturating byte index.
   logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist_ff, hist_in;
   logic [CNT_W-1:0]                  n_ff, n_in;

   logic              accept;
   logic              adv;
   logic              enable;
   logic              load_hit;
   logic              call_hit;
   logic              in_section;
   logic [DISP_W-1:0] disp;
   step_ctl_type      ctl;
   flow_type          s1_flow;
   logic [GRP_N-1:0][GRP_CNT_W-1:0] s1_grp;

   assign req_tready = adv;
   assign accept     = req_tvalid & req_tready;

   assign enable = (target_ff != '0) && (base_ff != '0) && (size_ff != '0);

   // A load starting at q = n - 2 counts only while q + window < size.
   assign in_section = ({1'b0, n_ff} + (CNT_W+1)'(WINDOW_BYTES - 2)) < {1'b0, size_ff};

   assign load_hit = (|n_ff[CNT_W-1:1]) && in_section &&
                     (hist_ff[3] == OP_REX_W) && (hist_ff[4] == OP_MOV) &&
                     (req_tdata == OP_RIPREL);

   // Little-endian displacement, its top byte being the one arriving now.
   assign disp = {req_tdata, hist_ff[4], hist_ff[3], hist_ff[2]};

   assign call_hit = (|n_ff[CNT_W-1:2]) && (hist_ff[1] == OP_CALL) &&
                     (disp == k_ff[DISP_W-1:0]) &&
                     (k_ff[ADDR_W-1:DISP_W] == {(ADDR_W-DISP_W){disp[DISP_W-1]}});

   assign ctl.step     = accept;
   assign ctl.last     = req_tlast;
   assign ctl.load_hit = load_hit;
   assign ctl.call_hit = call_hit;
   assign ctl.enable   = enable;

   // Register writes; an index past the list leaves everything unchanged.
   always_comb begin
      target_in = target_ff;
      base_in   = base_ff;
      size_in   = size_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET: target_in = csr_wdata;
            CSR_BASE:   base_in   = csr_wdata;
            CSR_SIZE:   size_in   = csr_wdata[SIZE_W-1:0];
            default:    ;
         endcase
      end
   end

   assign bias_cfg = target_in - base_in - CALL_BIAS;

   always_comb begin
      bias_in = bias_ff;
      k_in    = k_ff;
      n_in    = n_ff;
      hist_in = hist_ff;
      if (csr_wr_en) begin
         bias_in = bias_cfg;
         k_in    = bias_cfg - {{(ADDR_W-CNT_W){1'b0}}, n_ff};
      end else if (accept) begin
         if (req_tlast) begin
            // The section ends: the stream state starts over.
            hist_in = '0;
            n_in    = '0;
            k_in    = bias_ff;
         end else begin
            hist_in = {req_tdata, hist_ff[HIST_DEPTH-1:1]};
            if (n_ff != CNT_MAX) begin
               n_in = n_ff + 1'b1;
               k_in = k_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         base_ff   <= '0;
         size_ff   <= '0;
         bias_ff   <= '0 - CALL_BIAS;
         k_ff      <= '0 - CALL_BIAS;
         hist_ff   <= '0;
         n_ff      <= '0;
      end else begin
         target_ff <= target_in;
         base_ff   <= base_in;
         size_ff   <= size_in;
         bias_ff   <= bias_in;
         k_ff      <= k_in;
         hist_ff   <= hist_in;
         n_ff      <= n_in;
      end
   end

   rltcs_chain #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .adv     (adv),
      .s1_flow (s1_flow),
      .s1_grp  (s1_grp)
   );

   rltcs_tally #(
      .GRP_N (GRP_N)
   ) u_tally (
      .clock      (clock),
      .reset      (reset),
      .s1_flow    (s1_flow),
      .s1_grp     (s1_grp),
      .adv        (adv),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // After the last byte the index and the call offset are back at their start.
   `RLTCS_CHECK_NEXT(a_stream_restart, accept && req_tlast && !csr_wr_en,
                     n_ff == '0 && k_ff == bias_ff)
   // The call offset always matches bias minus the byte index.
   `RLTCS_CHECK(a_offset_tracks, 1'b1,
                k_ff == bias_ff - {{(ADDR_W-CNT_W){1'b0}}, n_ff})

endmodule

@@ tb/rip_load_then_call_scanner_test.sv @@
// ----------------------------------------------------------------------------
// rip_load_then_call_scanner_test
// Streams code sections into the load-then-call scanner and checks the count
// returned for each section against a cycle-free model of the scan. It covers
// directed corner cases first, then random sections with planted loads and
// calls, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module rip_load_then_call_scanner_test;
   import rltcs_pkg::*;

   localparam int WINDOW_BYTES    = 32;
   localparam int IDLE_PCT        = 21;
   localparam int HOLD_CYCLES     = 300;
   localparam int TAIL_CYCLES     = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_BYTES    = 120;
   localparam int RANDOM_SECTIONS = 3;

   // Index 3 is not a register; writes to it must leave the scan unchanged.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // A load stays open for ages 0 .. WINDOW_BYTES-4 bytes. A call completing
   // now can only serve loads aged 2 or more, since its opcode sits four bytes
   // back and the load's three bytes must come before it.
   localparam logic [63:0] LIVE_MASK  = (64'd1 << (WINDOW_BYTES - 3)) - 64'd1;
   localparam logic [63:0] REACH_MASK = LIVE_MASK & ~64'd3;

   // Addresses for the directed sections. The target lies below the base so
   // that planted calls carry negative displacements.
   localparam logic [63:0] NEAR_BASE   = 64'h0000_7FF6_1234_0000;
   localparam logic [63:0] NEAR_TARGET = 64'h0000_7FF6_1233_F000;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata  = '0;   // [7:0] code_byte
   logic                 req_tlast  = 1'b0; // last
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [CNT_W-1:0]     rsp_tdata;         // [31:0] match_count
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [ADDR_W-1:0]    csr_wdata  = '0;

   // Traffic shaping shared between the test sequence and the receiver.
   logic steady   = 1'b0;  // no idling on either side while set
   logic hold_req = 1'b0;  // asks the receiver for its one long stall
   logic hold_taken = 1'b0;
   int   hold_left  = 0;

   int errors      = 0;
   int idle_cycles = 0;
   int bytes_sent  = 0;

   // Scan model: configuration copy and per-section state.
   logic [63:0]       reg_target = '0;
   logic [63:0]       reg_base   = '0;
   logic [31:0]       reg_size   = '0;
   logic [BYTE_W-1:0] hist_bytes [HIST_DEPTH] = '{default: '0};
   logic [63:0]       open_loads = '0;
   logic [31:0]       byte_index = '0;
   logic [31:0]       load_hits  = '0;

   // Counts the scan owes, oldest first.
   logic [CNT_W-1:0]  counts_due [$];

   // Bytes of the section being built.
   logic [BYTE_W-1:0] image [$];

   rip_load_then_call_scanner #(.WINDOW_BYTES(WINDOW_BYTES)) DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Scan model, advanced once for every byte the block accepts.
   // ------------------------------------------------------------------------
   function automatic void advance_scan(input logic [7:0] code, input logic fin);
      logic [63:0] n;
      logic [63:0] disp;
      logic [63:0] dest;
      logic [63:0] served;
      logic [31:0] d32;
      logic [32:0] sum;
      logic        enabled;
      int          i;
      n = 64'(byte_index);
      enabled = (reg_target != '0) && (reg_base != '0) && (reg_size != '0);
      for (i = 0; i < HIST_DEPTH - 1; i++) begin
         hist_bytes[i] = hist_bytes[i + 1];
      end
      hist_bytes[HIST_DEPTH - 1] = code;
      open_loads = open_loads << 1;

      // A load that began two bytes back opens a window, but only if the
      // whole window lies inside the declared section size.
      if (n >= 64'd2 && hist_bytes[2] == OP_REX_W && hist_bytes[3] == OP_MOV &&
          hist_bytes[4] == OP_RIPREL) begin
         if (n - 64'd2 + 64'(WINDOW_BYTES) < 64'(reg_size)) begin
            open_loads[0] = 1'b1;
         end
      end

      // A call whose opcode sits four bytes back is now complete. Its
      // destination is taken modulo 2^64 from the end of the call.
      if (n >= 64'd4 && hist_bytes[0] == OP_CALL) begin
         d32  = {hist_bytes[4], hist_bytes[3], hist_bytes[2], hist_bytes[1]};
         disp = {{32{d32[31]}}, d32};
         dest = reg_base + (n - 64'd4) + 64'(CALL_LEN) + disp;
         if (dest == reg_target) begin
            served = open_loads & REACH_MASK;
            if (enabled) begin
               sum = {1'b0, load_hits} + 33'($countones(served));
               load_hits = sum[32] ? CNT_MAX : sum[31:0];
            end
            open_loads &= ~served;
         end
      end

      open_loads &= LIVE_MASK;
      if (byte_index != CNT_MAX) begin
         byte_index++;
      end

      if (fin) begin
         counts_due.push_back(enabled ? load_hits : '0);
         hist_bytes = '{default: '0};
         open_loads = '0;
         byte_index = '0;
         load_hits  = '0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Sender side.
   // ------------------------------------------------------------------------

   // Offers one byte and returns at the edge that accepts it. Idle cycles come
   // before the offer, so the valid line never drops while an item waits.
   task automatic send_byte(input logic [7:0] code, input logic fin);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      advance_scan(code, fin);
      bytes_sent++;
   endtask

   task automatic stream_section();
      foreach (image[i]) begin
         send_byte(image[i], i == image.size() - 1);
      end
   endtask

   // Waits until every owed count has been delivered, then lets the pipeline
   // drain before the caller touches the registers.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (counts_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_TARGET: reg_target = value;
         CSR_BASE:   reg_base   = value;
         CSR_SIZE:   reg_size   = value[31:0];
         default: ;
      endcase
   endtask

   // The upper half of the size write carries random bits, which the block
   // must drop.
   task automatic configure(input logic [63:0] target, input logic [63:0] base,
                            input logic [31:0] size);
      settle();
      write_csr(CSR_TARGET, target);
      write_csr(CSR_BASE, base);
      write_csr(CSR_SIZE, {$urandom, size});
      csr_wr_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Section building. A negative fill gives random filler bytes.
   // ------------------------------------------------------------------------
   task automatic make_section(input int len, input int fill);
      image.delete();
      repeat (len) image.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
   endtask

   task automatic plant_load(input int at);
      if (at >= 0 && at + 3 <= image.size()) begin
         image[at]     = OP_REX_W;
         image[at + 1] = OP_MOV;
         image[at + 2] = OP_RIPREL;
      end
   endtask

   // Plants a call aimed at the current target; a nonzero skew misses it.
   task automatic plant_call(input int at, input int skew);
      logic [31:0] d32;
      d32 = 32'(reg_target - reg_base - 64'(at) - 64'(CALL_LEN)) + 32'(skew);
      if (at >= 0 && at + 5 <= image.size()) begin
         image[at]     = OP_CALL;
         image[at + 1] = d32[7:0];
         image[at + 2] = d32[15:8];
         image[at + 3] = d32[23:16];
         image[at + 4] = d32[31:24];
      end
   endtask

   task automatic run_load_call(input int len, input int load_at, input int call_at);
      make_section(len, -1);
      plant_load(load_at);
      plant_call(call_at, 0);
      stream_section();
   endtask

   // Mostly well-formed: a few loads, most followed by a call somewhere around
   // their window, some calls that miss by one, some that come too early.
   // One section in ten is plain noise.
   task automatic random_section(input int len);
      int loads;
      int at;
      make_section(len, -1);
      if ($urandom_range(9) != 0) begin
         loads = $urandom_range(4);
         repeat (loads) begin
            at = $urandom_range(len - 1);
            plant_load(at);
            if ($urandom_range(3) != 0) begin
               plant_call(at + $urandom_range(3, 30), ($urandom_range(7) == 0) ? 1 : 0);
            end
            if ($urandom_range(7) == 0) begin
               plant_call(at - $urandom_range(5, 12), 0);
            end
         end
      end
      stream_section();
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Any zero register turns counting off, even when a call lands on the
   // target. Right after reset all three registers are zero.
   task automatic test_disabled_scan();
      run_load_call(24, 1, 12);
      configure(64'h0, NEAR_BASE, 40);
      run_load_call(24, 1, 12);
      configure(NEAR_TARGET, 64'h0, 40);
      run_load_call(24, 1, 12);
      configure(NEAR_TARGET, NEAR_BASE, 32'h0);
      run_load_call(24, 1, 12);
   endtask

   // Two loads share one call inside the first load's window; a second call at
   // the far edge of that window adds nothing; a call one byte past the window
   // misses; a call with a wrong displacement misses.
   task automatic test_load_then_call();
      configure(NEAR_TARGET, NEAR_BASE, 64);
      make_section(64, -1);
      plant_load(0);
      plant_load(3);
      plant_call(26, 0);
      plant_call(14, 0);
      plant_load(30);
      plant_call(57, 0);
      plant_call(40, 1);
      stream_section();
   endtask

   // A section no longer than the window registers no loads; one byte more
   // lets the load at position zero count.
   task automatic test_small_section();
      configure(NEAR_TARGET, NEAR_BASE, WINDOW_BYTES);
      run_load_call(33, 0, 10);
      configure(NEAR_TARGET, NEAR_BASE, WINDOW_BYTES + 1);
      run_load_call(33, 0, 10);
   endtask

   // The stream ends long before the declared size: a load whose call was
   // already seen counts, one still waiting does not.
   task automatic test_short_stream();
      configure(NEAR_TARGET, NEAR_BASE, 32'hFFFF_FFFF);
      make_section(20, -1);
      plant_load(0);
      plant_call(10, 0);
      plant_load(12);
      stream_section();
   endtask

   // The stream runs past the declared size: later loads do not register,
   // but calls there still serve an earlier load.
   task automatic test_long_stream();
      configure(NEAR_TARGET, NEAR_BASE, 36);
      make_section(70, -1);
      plant_load(2);
      plant_load(10);
      plant_load(40);
      plant_call(20, 0);
      plant_call(50, 0);
      stream_section();
   endtask

   // A write to the spare index must not disturb any register.
   task automatic test_spare_index();
      settle();
      write_csr(CSR_SPARE, '1);
      csr_wr_en <= 1'b0;
      run_load_call(30, 0, 20);
   endtask

   // A destination that wraps around the top of the address space and one at
   // its top, with all-ones and all-zeros filler around planted instructions.
   task automatic test_address_wrap();
      configure(64'h0000_0000_0000_0100, 64'hFFFF_FFFF_FFFF_FFF0, 40);
      make_section(40, 8'hFF);
      plant_load(4);
      plant_call(20, 0);
      stream_section();
      configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_8000_0000, 40);
      make_section(40, 8'h00);
      plant_load(0);
      plant_call(25, 0);
      stream_section();
   endtask

   // Back-to-back sections with no idling on either side, so that results
   // leave while the next section's bytes flow in.
   task automatic test_back_to_back();
      configure(NEAR_TARGET, NEAR_BASE, 40);
      steady <= 1'b1;
      repeat (3) random_section(36);
      steady <= 1'b0;
   endtask

   // The receiver stalls for a long stretch while short sections keep coming,
   // so the result register fills and the block must stop taking bytes.
   task automatic test_result_backpressure();
      configure(NEAR_TARGET, NEAR_BASE, 48);
      hold_req <= 1'b1;
      repeat (8) random_section($urandom_range(6, 20));
   endtask

   task automatic test_random_sections();
      logic [63:0] base;
      logic [63:0] target;
      logic [31:0] size;
      logic [31:0] offset;
      int          len;
      int          sections;
      int          start;
      sections = 0;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES || sections < RANDOM_SECTIONS) begin
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(15))
               0:       base = '0;
               1:       base = '1;
               default: base = {$urandom, $urandom};
            endcase
            // Most targets sit within reach of a 32-bit displacement.
            offset = $urandom;
            case ($urandom_range(15))
               0:       target = '0;
               1:       target = '1;
               2:       target = {$urandom, $urandom};
               default: target = base + {{34{offset[29]}}, offset[29:0]};
            endcase
            case ($urandom_range(9))
               0:       size = '0;
               1:       size = '1;
               2:       size = $urandom_range(1, WINDOW_BYTES);
               default: size = $urandom_range(WINDOW_BYTES + 1, 64);
            endcase
            configure(target, base, size);
         end
         // Usually the stream matches the declared size; otherwise it ends
         // early or runs on past it.
         if (reg_size != '0 && reg_size <= 64 && $urandom_range(9) < 7) begin
            len = int'(reg_size);
         end else begin
            len = $urandom_range(1, 72);
         end
         random_section(len);
         sections++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus the one long hold requested by the
   // backpressure test, counted here in cycles.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_left  = HOLD_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Every accepted count is compared with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (counts_due.size() == 0) begin
            $display("%0t: match_count %0d arrived with none expected", $time, rsp_tdata);
            errors++;
         end else begin
            if (rsp_tdata !== counts_due[0]) begin
               $display("%0t: match_count expected %0d, actual %0d",
                        $time, counts_due[0], rsp_tdata);
               errors++;
            end
            void'(counts_due.pop_front());
         end
      end
   end

   // Ends the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("rip_load_then_call_scanner_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_scan();
      test_load_then_call();
      test_small_section();
      test_short_stream();
      test_long_stream();
      test_spare_index();
      test_address_wrap();
      test_back_to_back();
      test_result_backpressure();
      test_random_sections();

      settle();
      if (errors == 0) begin
         $display("rip_load_then_call_scanner_test: done, clean");
      end else begin
         $display("rip_load_then_call_scanner_test: done, errors");
      end
      $finish;
   end

endmodule
